// ===== sv/tcb_pkg.sv =====
package tcb_pkg;

   localparam int unsigned CoordWidth  = 16;
   localparam int unsigned DiffWidth   = CoordWidth + 1;
   localparam int unsigned ProdWidth   = 2 * DiffWidth;
   localparam int unsigned EdgeWidth   = ProdWidth + 1;
   localparam int unsigned WeightWidth = 17;
   localparam int unsigned DivStages   = WeightWidth;
   localparam logic [WeightWidth-1:0] WeightOne = WeightWidth'(65536);

   typedef struct packed {
      logic signed [CoordWidth-1:0] point_x;
      logic signed [CoordWidth-1:0] point_y;
      logic signed [CoordWidth-1:0] vert1_x;
      logic signed [CoordWidth-1:0] vert1_y;
      logic signed [CoordWidth-1:0] vert2_x;
      logic signed [CoordWidth-1:0] vert2_y;
      logic signed [CoordWidth-1:0] vert3_x;
      logic signed [CoordWidth-1:0] vert3_y;
   } req_type;

   typedef struct packed {
      logic                   covered;
      logic [WeightWidth-1:0] weight1;
      logic [WeightWidth-1:0] weight2;
      logic [WeightWidth-1:0] weight3;
   } rsp_type;

   typedef struct packed {
      logic                            covered;
      logic [EdgeWidth-1:0]            den;
      logic [2:0][EdgeWidth-1:0]       num;
   } tcb_edge_out_type;

   typedef struct packed {
      logic                            covered;
      logic [EdgeWidth-1:0]            den;
      logic [2:0][EdgeWidth-1:0]       rem;
      logic [2:0][WeightWidth-1:0]     quo;
   } tcb_div_stage_type;

endpackage

// ===== sv/tcb_edge.sv =====
module tcb_edge (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  tcb_pkg::req_type          in_data,
   input  logic                      winding_ccw,
   output logic                      out_valid,
   output tcb_pkg::tcb_edge_out_type out_data
);

   localparam int unsigned DW = tcb_pkg::DiffWidth;
   localparam int unsigned PW = tcb_pkg::ProdWidth;
   localparam int unsigned EW = tcb_pkg::EdgeWidth;

   // Stage A: coordinate differences and fill-rule flags.
   logic signed [DW-1:0]       diff_in [16];
   logic signed [DW-1:0]       diff_ff [16];
   logic [2:0]                 tl_in, tl_ff;
   logic                       ccw_a_ff;
   logic                       valid_a_ff;

   // Stage B: products.
   logic signed [PW-1:0]       prod_in [8];
   logic signed [PW-1:0]       prod_ff [8];
   logic [2:0]                 tl_b_ff;
   logic                       ccw_b_ff;
   logic                       valid_b_ff;

   // Stage C: edge values.
   logic signed [EW-1:0]       edge_in [4];
   logic signed [EW-1:0]       edge_ff [4];
   logic [2:0]                 tl_c_ff;
   logic                       ccw_c_ff;
   logic                       valid_c_ff;

   // Stage D: winding, coverage and divider operands.
   logic signed [EW-1:0]       wval [4];
   logic [2:0]                 pass;
   logic                       area_pos;
   tcb_pkg::tcb_edge_out_type  out_in, out_ff;
   logic                       valid_d_ff;

   function automatic logic signed [DW-1:0] sub16(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
      logic signed [DW-1:0] ae;
      logic signed [DW-1:0] be;
      ae = {a[15], a};
      be = {b[15], b};
      return ae - be;
   endfunction

   function automatic logic is_tl(input logic signed [DW-1:0] dx,
                                  input logic signed [DW-1:0] dy);
      return (dy == '0 && !dx[DW-1] && dx != '0) || (!dy[DW-1] && dy != '0);
   endfunction

   always_comb begin
      diff_in[0]  = sub16(in_data.vert3_x, in_data.vert2_x);
      diff_in[1]  = sub16(in_data.vert1_y, in_data.vert2_y);
      diff_in[2]  = sub16(in_data.vert1_x, in_data.vert2_x);
      diff_in[3]  = sub16(in_data.vert3_y, in_data.vert2_y);
      diff_in[4]  = sub16(in_data.point_x, in_data.vert3_x);
      diff_in[5]  = sub16(in_data.vert2_y, in_data.vert3_y);
      diff_in[6]  = sub16(in_data.vert2_x, in_data.vert3_x);
      diff_in[7]  = sub16(in_data.point_y, in_data.vert3_y);
      diff_in[8]  = sub16(in_data.point_x, in_data.vert1_x);
      diff_in[9]  = sub16(in_data.vert3_y, in_data.vert1_y);
      diff_in[10] = sub16(in_data.vert3_x, in_data.vert1_x);
      diff_in[11] = sub16(in_data.point_y, in_data.vert1_y);
      diff_in[12] = sub16(in_data.point_x, in_data.vert2_x);
      diff_in[13] = diff_in[1];
      diff_in[14] = diff_in[2];
      diff_in[15] = sub16(in_data.point_y, in_data.vert2_y);
      tl_in[0] = is_tl(diff_in[0], diff_in[3]);
      tl_in[1] = is_tl(sub16(in_data.vert1_x, in_data.vert3_x),
                       sub16(in_data.vert1_y, in_data.vert3_y));
      tl_in[2] = is_tl(sub16(in_data.vert2_x, in_data.vert1_x),
                       sub16(in_data.vert2_y, in_data.vert1_y));
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         prod_in[i] = diff_ff[2*i] * diff_ff[2*i+1];
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         edge_in[i] = EW'(prod_ff[2*i]) - EW'(prod_ff[2*i+1]);
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         wval[i] = ccw_c_ff ? edge_ff[i] : -edge_ff[i];
      end
      area_pos = !wval[0][EW-1] && wval[0] != '0;
      for (int i = 0; i < 3; i++) begin
         pass[i] = (wval[i+1] == '0) ? tl_c_ff[i] : !wval[i+1][EW-1];
      end
      out_in.covered = area_pos && (&pass);
      out_in.den = out_in.covered ? wval[0] : EW'(1);
      for (int i = 0; i < 3; i++) begin
         out_in.num[i] = out_in.covered ? wval[i+1] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
         valid_d_ff <= valid_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff  <= diff_in;
         tl_ff    <= tl_in;
         ccw_a_ff <= winding_ccw;
         prod_ff  <= prod_in;
         tl_b_ff  <= tl_ff;
         ccw_b_ff <= ccw_a_ff;
         edge_ff  <= edge_in;
         tl_c_ff  <= tl_b_ff;
         ccw_c_ff <= ccw_b_ff;
         out_ff   <= out_in;
      end
   end

   assign out_valid = valid_d_ff;
   assign out_data  = out_ff;

endmodule

// ===== sv/tcb_div.sv =====
module tcb_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  tcb_pkg::tcb_edge_out_type in_data,
   output logic                      out_valid,
   output tcb_pkg::rsp_type          out_data
);

   localparam int unsigned NS = tcb_pkg::DivStages;
   localparam int unsigned EW = tcb_pkg::EdgeWidth;
   localparam int unsigned QW = tcb_pkg::WeightWidth;

   tcb_pkg::tcb_div_stage_type stage_in [NS];
   tcb_pkg::tcb_div_stage_type stage_ff [NS];
   logic [NS-1:0]              valid_ff;

   // One quotient bit per stage, restoring division of num * 2^16 by den.
   always_comb begin
      stage_in[0].covered = in_data.covered;
      stage_in[0].den     = in_data.den;
      stage_in[0].rem     = in_data.num;
      stage_in[0].quo     = '0;
      for (int s = 1; s < NS; s++) begin
         stage_in[s].covered = stage_ff[s-1].covered;
         stage_in[s].den     = stage_ff[s-1].den;
         for (int l = 0; l < 3; l++) begin
            stage_in[s].rem[l] = {stage_ff[s-1].rem[l][EW-2:0], 1'b0};
         end
         stage_in[s].quo = stage_ff[s-1].quo;
      end
      for (int s = 0; s < NS; s++) begin
         for (int l = 0; l < 3; l++) begin
            if (stage_in[s].rem[l] >= stage_in[s].den) begin
               stage_in[s].rem[l] = stage_in[s].rem[l] - stage_in[s].den;
               stage_in[s].quo[l] = {stage_in[s].quo[l][QW-2:0], 1'b1};
            end else begin
               stage_in[s].quo[l] = {stage_in[s].quo[l][QW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < NS; s++) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign out_valid        = valid_ff[NS-1];
   assign out_data.covered = stage_ff[NS-1].covered;
   assign out_data.weight1 = stage_ff[NS-1].quo[0];
   assign out_data.weight2 = stage_ff[NS-1].quo[1];
   assign out_data.weight3 = stage_ff[NS-1].quo[2];

endmodule

// ===== sv/triangle_coverage_barycentric.sv =====
// Triangle coverage with barycentric weights. Each item carries a sample point and three
// vertices in signed Q12.4; the result says whether the point is covered under the top-left
// fill rule and gives three unsigned Q1.16 weights, all zero when it is not covered. The
// block takes one item per cycle while no result waits at the output; four stages form
// the differences, products, edge values and coverage, and a divider with one quotient
// bit per stage adds seventeen more. The whole pipeline stalls together only
// while a result waits at the output. The winding register resets to counter-clockwise.
module triangle_coverage_barycentric (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tcb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tcb_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_wdata
);

   logic                      winding_ccw_ff;
   logic                      advance;
   logic                      edge_valid;
   tcb_pkg::tcb_edge_out_type edge_data;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         winding_ccw_ff <= 1'b1;
      end else if (csr_we) begin
         winding_ccw_ff <= csr_wdata;
      end
   end

   tcb_edge u_edge (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid),
      .in_data     (req_data),
      .winding_ccw (winding_ccw_ff),
      .out_valid   (edge_valid),
      .out_data    (edge_data)
   );

   tcb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (edge_valid),
      .in_data   (edge_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_uncovered_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.covered |->
         rsp_data.weight1 == '0 && rsp_data.weight2 == '0 && rsp_data.weight3 == '0)
      else $error("uncovered item has non-zero weights");

   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.covered |->
         (19'(rsp_data.weight1) + 19'(rsp_data.weight2) + 19'(rsp_data.weight3)
            <= 19'(tcb_pkg::WeightOne)) &&
         (19'(rsp_data.weight1) + 19'(rsp_data.weight2) + 19'(rsp_data.weight3)
            + 19'(2) >= 19'(tcb_pkg::WeightOne)))
      else $error("covered weights do not sum to one");

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item accepted while pipeline is stalled");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int Latency    = 21;
   localparam int WatchLimit = 4000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   tcb_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   tcb_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic             csr_wdata = 1'b0;

   tcb_pkg::req_type pending_items[$];
   tcb_pkg::rsp_type coverage_expected[$];
   logic    winding_ccw = 1'b1;
   int      mismatches = 0;
   int      idle_cycles = 0;
   int      burst_left = 0;
   int      gap_left = 0;
   int      hold_off = 0;
   bit      driver_paused = 1'b0;

   triangle_coverage_barycentric uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint edge_of(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy);
      return (cx - bx) * (ay - by) - (ax - bx) * (cy - by);
   endfunction

   function automatic bit is_top_left(longint ax, longint ay, longint bx, longint by);
      return ((by - ay) == 0 && (bx - ax) > 0) || (by - ay) > 0;
   endfunction

   function automatic bit edge_passes(longint w, bit tl);
      return (w == 0) ? tl : (w > 0);
   endfunction

   function automatic logic [tcb_pkg::WeightWidth-1:0] weight_of(longint w, longint area);
      longint q;
      q = (w <<< 16) / area;
      if (q > 65536) q = 65536;
      return q[tcb_pkg::WeightWidth-1:0];
   endfunction

   function automatic tcb_pkg::rsp_type predict_coverage(tcb_pkg::req_type it, logic ccw);
      longint px, py, x1, y1, x2, y2, x3, y3, area, w1, w2, w3;
      tcb_pkg::rsp_type r;
      px = it.point_x; py = it.point_y;
      x1 = it.vert1_x; y1 = it.vert1_y;
      x2 = it.vert2_x; y2 = it.vert2_y;
      x3 = it.vert3_x; y3 = it.vert3_y;
      area = edge_of(x1, y1, x2, y2, x3, y3);
      w1 = edge_of(x2, y2, x3, y3, px, py);
      w2 = edge_of(x3, y3, x1, y1, px, py);
      w3 = edge_of(x1, y1, x2, y2, px, py);
      if (!ccw) begin
         area = -area; w1 = -w1; w2 = -w2; w3 = -w3;
      end
      r = '0;
      if (area > 0 && edge_passes(w1, is_top_left(x2, y2, x3, y3))
          && edge_passes(w2, is_top_left(x3, y3, x1, y1))
          && edge_passes(w3, is_top_left(x1, y1, x2, y2))) begin
         r.covered = 1'b1;
         r.weight1 = weight_of(w1, area);
         r.weight2 = weight_of(w2, area);
         r.weight3 = weight_of(w3, area);
      end
      return r;
   endfunction

   function automatic logic [15:0] rand_coord(int span);
      if ($urandom_range(0, 9) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 2 * span) - span);
   endfunction

   function automatic tcb_pkg::req_type rand_item();
      tcb_pkg::req_type it;
      int span, mode;
      logic [15:0] a, b;
      mode = $urandom_range(0, 9);
      span = (mode < 3) ? 64 : (mode < 7) ? 2048 : 32767;
      it.vert1_x = rand_coord(span); it.vert1_y = rand_coord(span);
      it.vert2_x = rand_coord(span); it.vert2_y = rand_coord(span);
      it.vert3_x = rand_coord(span); it.vert3_y = rand_coord(span);
      if (mode == 0) begin
         it.vert2_y = it.vert1_y;
      end else if (mode == 1) begin
         it.vert3_x = it.vert2_x;
      end
      case ($urandom_range(0, 5))
         0: begin
            it.point_x = it.vert1_x; it.point_y = it.vert1_y;
         end
         1: begin
            a = it.vert1_x + it.vert2_x; b = it.vert1_y + it.vert2_y;
            it.point_x = {a[15], a[15:1]}; it.point_y = {b[15], b[15:1]};
         end
         2: begin
            it.point_x = rand_coord(32767); it.point_y = rand_coord(32767);
         end
         default: begin
            it.point_x = 16'((32'(signed'(it.vert1_x)) + 32'(signed'(it.vert2_x))
                             + 32'(signed'(it.vert3_x))) / 3
                             + int'($urandom_range(0, 6)) - 3);
            it.point_y = 16'((32'(signed'(it.vert1_y)) + 32'(signed'(it.vert2_y))
                             + 32'(signed'(it.vert3_y))) / 3
                             + int'($urandom_range(0, 6)) - 3);
         end
      endcase
      return it;
   endfunction

   function automatic tcb_pkg::req_type make_item(int px, int py, int ax, int ay, int bx,
                                                  int by, int cx, int cy);
      tcb_pkg::req_type it;
      it.point_x = 16'(px); it.point_y = 16'(py);
      it.vert1_x = 16'(ax); it.vert1_y = 16'(ay);
      it.vert2_x = 16'(bx); it.vert2_y = 16'(by);
      it.vert3_x = 16'(cx); it.vert3_y = 16'(cy);
      return it;
   endfunction

   task automatic queue_item(tcb_pkg::req_type it);
      pending_items = {pending_items, it};
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_valid || coverage_expected.size() != 0)
         @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   task automatic write_winding(logic v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      winding_ccw <= v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_directed();
      queue_item(make_item(16, 16, 0, 0, 64, 0, 0, 64));
      queue_item(make_item(16, 16, 0, 0, 0, 64, 64, 0));
      queue_item(make_item(0, 0, 0, 0, 64, 0, 0, 64));
      queue_item(make_item(32, 0, 0, 0, 64, 0, 0, 64));
      queue_item(make_item(0, 32, 0, 0, 64, 0, 0, 64));
      queue_item(make_item(32, 32, 0, 0, 64, 0, 0, 64));
      queue_item(make_item(64, 0, 0, 0, 64, 0, 0, 64));
      queue_item(make_item(0, 64, 0, 0, 64, 0, 0, 64));
      queue_item(make_item(100, 100, 0, 0, 64, 0, 0, 64));
      queue_item(make_item(5, 5, 0, 0, 32, 32, 64, 64));
      queue_item(make_item(0, 0, 0, 0, 0, 0, 0, 0));
      queue_item(make_item(0, 0, -32768, -32768, 32767, -32768, 0, 32767));
      queue_item(make_item(0, 0, -32768, -32768, 0, 32767, 32767, -32768));
      queue_item(make_item(-32768, -32768, -32768, -32768, 32767, -32768,
                           -32768, 32767));
      queue_item(make_item(32767, 32767, -32768, 32767, 32767, -32768,
                           32767, 32767));
      queue_item(make_item(-1, -1, -32768, -32768, 32767, -32768, 32767,
                           32767));
      queue_item(make_item(1, 1, 0, 0, 2, 0, 0, 2));
      queue_item(make_item(32767, -32768, 32767, -32768, -32768, 32767,
                           32767, 32767));
   endtask

   task automatic add_random(int n);
      repeat (n) queue_item(rand_item());
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      add_directed();
      wait_drained();
      write_winding(1'b0);
      add_directed();
      add_random(400);
      wait_drained();
      write_winding(1'b1);
      add_random(300);
      repeat (30) @(posedge clock);
      hold_off <= 300;
      add_random(200);
      wait_drained();
      write_winding(1'b0);
      add_random(500);
      wait_drained();
      write_winding(1'b1);
      add_random(514);
      wait_drained();
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid)
            coverage_expected = {coverage_expected, predict_coverage(req_data, winding_ccw)};
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req_data <= pending_items.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (coverage_expected.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected result %p", rsp_data);
            end else begin
               if (rsp_data !== coverage_expected[0]) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("mismatch: expected %p, got %p", coverage_expected[0], rsp_data);
               end
               void'(coverage_expected.pop_front());
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 15) < 3 && ($urandom & 1)) ? 1'b0 : 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchLimit) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== triangle_coverage_barycentric.f =====
sv/tcb_pkg.sv
sv/tcb_edge.sv
sv/tcb_div.sv
sv/triangle_coverage_barycentric.sv
tb/tb_top.sv
